FILE: design/lqfl_pkg.sv
// Package for the linked queue block: node count, operation and status codes,
// and the structs passed along the cell chain.
// No dependencies.
package lqfl_pkg;

    localparam int NODES = 8;
    localparam int CNT_W = $clog2(NODES + 1);

    typedef enum logic [1:0] {
        OP_ENQ = 2'd0,
        OP_INS = 2'd1,
        OP_DEQ = 2'd2,
        OP_NOP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Insertion wave moving one cell down the chain per cycle.
    typedef struct packed {
        logic              act;
        logic              push;
        logic              enq;
        logic signed [7:0] val;
    } t_wave;

    // Content of one queue position.
    typedef struct packed {
        logic              vld;
        logic signed [7:0] val;
    } t_slot;

endpackage

FILE: design/lqfl_cell.sv
// One queue position of the cell chain: holds an element, absorbs or forwards
// the insertion wave, and takes its right neighbor's element on a dequeue.
// Depends on lqfl_pkg.
module lqfl_cell
    import lqfl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_wave i_wave,
    output t_wave o_wave,
    input  logic  i_shift,
    input  t_slot i_right,
    output t_slot o_slot
);

    logic              r_vld;
    logic signed [7:0] r_val;
    logic              r_wact;
    logic              r_wpush;
    logic              r_wenq;
    logic signed [7:0] r_wval;

    logic              n_vld;
    logic signed [7:0] n_val;
    logic              n_wact;
    logic              n_wpush;
    logic              n_wenq;
    logic signed [7:0] n_wval;

    always_comb begin
        n_vld   = r_vld;
        n_val   = r_val;
        n_wact  = 1'b0;
        n_wpush = i_wave.push;
        n_wenq  = i_wave.enq;
        n_wval  = i_wave.val;
        if (i_shift) begin
            n_vld = i_right.vld;
            n_val = i_right.val;
        end else if (i_wave.act) begin
            if (!r_vld) begin
                // first free position: the wave ends here
                n_vld = 1'b1;
                n_val = i_wave.val;
            end else if (i_wave.push || (!i_wave.enq && !(i_wave.val > r_val))) begin
                // take the carried element, push the old one onward
                n_val   = i_wave.val;
                n_wact  = 1'b1;
                n_wpush = 1'b1;
                n_wval  = r_val;
            end else begin
                n_wact = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_wact <= 1'b0;
        end else begin
            r_vld  <= n_vld;
            r_wact <= n_wact;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_wpush <= n_wpush;
        r_wenq  <= n_wenq;
        r_wval  <= n_wval;
    end

    assign o_wave = '{act: r_wact, push: r_wpush, enq: r_wenq, val: r_wval};
    assign o_slot = '{vld: r_vld, val: r_val};

endmodule

FILE: design/linked_queue_with_free_list_top.sv
// Queue of signed bytes kept in order along a chain of NODES cells.
// Enqueue or sorted insert into k elements: the insertion wave moves one cell per cycle
// down the chain past the k occupied cells while the block waits in S_WALK; dequeue,
// full, empty and unused op skip S_WALK. The result loads in S_DONE when the output is
// free, then S_IDLE takes the next beat. Synchronous active-low reset empties the chain.
module linked_queue_with_free_list_top
    import lqfl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [1:0] op, [9:2] value, [15:10] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // [1:0] status, [9:2] head_value, [13:10] occupancy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_left;
    t_status           r_status;
    logic signed [7:0] r_hv;
    logic [3:0]        r_occ;
    logic              r_ovld;
    logic [15:0]       r_odata;

    t_wave             w [NODES+1];
    t_slot             slot [NODES];
    logic [NODES-1:0]  vld_vec;

    logic              in_acc;
    t_op               in_op;
    logic signed [7:0] in_val;
    logic              full;
    logic              empty;
    logic              shift;
    logic              out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_op         = t_op'(s_axis_tdata[1:0]);
    assign in_val        = s_axis_tdata[9:2];
    assign full          = vld_vec[NODES-1];
    assign empty         = !vld_vec[0];
    assign shift         = in_acc && (in_op == OP_DEQ) && !empty;
    assign out_free      = !r_ovld || m_axis_tready;

    assign w[0] = '{act:  in_acc && ((in_op == OP_ENQ) || (in_op == OP_INS)) && !full,
                    push: 1'b0,
                    enq:  (in_op == OP_ENQ),
                    val:  in_val};

    for (genvar i = 0; i < NODES; i++) begin : g_cell
        t_slot right;
        if (i < NODES - 1) begin : g_mid
            assign right = slot[i+1];
        end else begin : g_last
            assign right = '0;
        end
        lqfl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wave  (w[i]),
            .o_wave  (w[i+1]),
            .i_shift (shift),
            .i_right (right),
            .o_slot  (slot[i])
        );
        assign vld_vec[i] = slot[i].vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovld  <= 1'b0;
        end else begin
            // a beat leaving while the next result loads is handled in S_DONE
            if (r_ovld && m_axis_tready && (r_state != S_DONE)) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (in_op)
                            OP_ENQ, OP_INS: begin
                                r_hv <= '0;
                                if (full) begin
                                    r_status <= ST_FULL;
                                    r_occ    <= 4'(r_count);
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_DONE;
                                    r_count  <= r_count + 1'b1;
                                    r_occ    <= 4'(r_count + 1'b1);
                                    r_left   <= r_count - 1'b1;
                                    if (r_count != '0) begin
                                        r_state <= S_WALK;
                                    end else begin
                                        r_state <= S_DONE;
                                    end
                                end
                            end
                            OP_DEQ: begin
                                r_state <= S_DONE;
                                if (empty) begin
                                    r_hv     <= '0;
                                    r_status <= ST_EMPTY;
                                    r_occ    <= 4'(r_count);
                                end else begin
                                    r_hv     <= slot[0].val;
                                    r_status <= ST_DONE;
                                    r_count  <= r_count - 1'b1;
                                    r_occ    <= 4'(r_count - 1'b1);
                                end
                            end
                            default: begin
                                r_hv     <= '0;
                                r_status <= ST_DONE;
                                r_occ    <= 4'(r_count);
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    // the wave lands in the first free cell on the last count
                    if (r_left == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_left <= r_left - 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ovld  <= 1'b1;
                        r_odata <= {2'b00, r_occ, r_hv, r_status};
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;

`ifndef SYNTH
    a_wave_stays_in_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w[NODES].act)
        else $error("insertion wave ran off the end of the cell chain");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(NODES))
        else $error("element count above node count");

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(vld_vec) == int'(r_count)))
        else $error("element count disagrees with occupied cells");
`endif

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for linked_queue_with_free_list_top: directed and random beats
// checked against a behavioral mirror of the linked queue (enqueue, sorted insert, dequeue).
// Depends on lqfl_pkg and the top-level RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lqfl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BEATS = 1600;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        t_status           status;
        logic signed [7:0] head_val;
        logic [3:0]        occ;
    } t_reply;

    // Mirror of the queue contents in order, head first; the free list only matters
    // through the element count, so it is not kept.
    class t_queue_mirror;
        logic signed [7:0] elems[$];
        t_reply            pending_replies[$];
        int                errors;

        function new();
            errors = 0;
        endfunction

        function int depth();
            return elems.size();
        endfunction

        function int pending_count();
            return pending_replies.size();
        endfunction

        function void apply_op(t_op op, logic signed [7:0] val);
            t_reply r;
            int     pos;
            r.status   = ST_DONE;
            r.head_val = '0;
            case (op)
                OP_ENQ: begin
                    if (elems.size() >= NODES) r.status = ST_FULL;
                    else elems.push_back(val);
                end
                OP_INS: begin
                    if (elems.size() >= NODES) begin
                        r.status = ST_FULL;
                    end else begin
                        // walk past the leading run strictly smaller than val
                        pos = 0;
                        while (pos < elems.size() && val > elems[pos]) pos++;
                        elems.insert(pos, val);
                    end
                end
                OP_DEQ: begin
                    if (elems.size() == 0) r.status = ST_EMPTY;
                    else r.head_val = elems.pop_front();
                end
                default: ;
            endcase
            r.occ = 4'(elems.size());
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic [15:0] d);
            t_reply  e;
            t_status got_status;
            logic signed [7:0] got_head;
            logic [3:0] got_occ;
            got_status = t_status'(d[1:0]);
            got_head   = d[9:2];
            got_occ    = d[13:10];
            if (pending_replies.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected beat status=%0d head=%0d occ=%0d",
                             $realtime, d[1:0], got_head, got_occ);
                errors++;
                return;
            end
            e = pending_replies.pop_front();
            if (got_status !== e.status || got_head !== e.head_val || got_occ !== e.occ) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: mismatch exp status=%0d head=%0d occ=%0d, got %0d %0d %0d",
                             $realtime, e.status, e.head_val, e.occ,
                             d[1:0], got_head, got_occ);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [1:0] op, [9:2] value, [15:10] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [1:0] status, [9:2] head_value, [13:10] occupancy

    bit            no_idle = 1'b0;
    int            cycles = 0;
    t_queue_mirror mirror = new();

    linked_queue_with_free_list_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** linked_queue_with_free_list_top: FAILED **");
            $finish;
        end
    end

    // Offer one beat after random idle cycles; return at the edge that accepts it.
    task automatic send_item(t_op op, logic [7:0] val);
        while (!no_idle && $urandom_range(99) < 35) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, val, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        mirror.apply_op(op, val);
    endtask

    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (mirror.pending_count() != 0) @(posedge i_clk);
    endtask

    function automatic t_op pick_op(int mode);
        int roll;
        roll = $urandom_range(99);
        case (mode)
            0:       return t_op'((roll < 40) ? OP_ENQ : (roll < 80) ? OP_INS :
                                  (roll < 95) ? OP_DEQ : OP_NOP);
            1:       return t_op'((roll < 15) ? OP_ENQ : (roll < 30) ? OP_INS :
                                  (roll < 95) ? OP_DEQ : OP_NOP);
            default: return t_op'((roll < 30) ? OP_ENQ : (roll < 60) ? OP_INS :
                                  (roll < 95) ? OP_DEQ : OP_NOP);
        endcase
    endfunction

    function automatic logic [7:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60) return 8'($urandom_range(255));
        // a narrow band around zero gives plenty of equal elements
        if (roll < 90) return 8'($urandom_range(4) - 2);
        case ($urandom_range(3))
            0:       return 8'h80;
            1:       return 8'h7F;
            2:       return 8'h00;
            default: return 8'hFF;
        endcase
    endfunction

    // Receiver: random stalls, one long hold-off so the block backs up its input.
    initial begin
        int hold_left;
        int n_beats;
        hold_left = 0;
        n_beats   = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                mirror.check_reply(m_axis_tdata);
                n_beats++;
                if (n_beats == 400) hold_left = 200;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(99) < 35) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int mode;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty dequeue, unused op, unordered insert, equal values, full drops
        send_item(OP_DEQ, 8'h5A);
        send_item(OP_NOP, 8'hA5);
        send_item(OP_ENQ, 8'd5);
        send_item(OP_ENQ, 8'hFD);
        send_item(OP_INS, 8'd0);
        send_item(OP_INS, 8'h7F);
        send_item(OP_INS, 8'h80);
        send_item(OP_ENQ, 8'h7F);
        send_item(OP_ENQ, 8'hFF);
        send_item(OP_INS, 8'hFF);
        send_item(OP_ENQ, 8'd1);
        send_item(OP_INS, 8'd1);
        send_item(OP_NOP, 8'hFF);
        repeat (NODES) send_item(OP_DEQ, 8'h00);
        send_item(OP_DEQ, 8'hFF);
        drain_replies();

        mode = 2;
        for (int k = 0; k < RANDOM_BEATS; k++) begin
            if (k % 40 == 0) mode = $urandom_range(2);
            no_idle = (k >= 1000 && k < 1300);
            if (k == 800) drain_replies();
            send_item(pick_op(mode), pick_value());
        end

        drain_replies();
        repeat (20) @(posedge i_clk);
        if (mirror.errors == 0 && mirror.pending_count() == 0) begin
            $display("** linked_queue_with_free_list_top: PASSED **");
        end else begin
            $display("** linked_queue_with_free_list_top: FAILED **");
        end
        $finish;
    end

endmodule
